>>> hw/rtl/bmip_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// bmip_pkg
// Shared types, widths and constants of the bidirectional incremental PID
// speed controller.
// ============================================================================
package bmip_pkg;

    // channel count and speed sample width
    localparam int MOTORS      = 2;
    localparam int SPEED_WIDTH = 16;

    // arithmetic widths
    localparam int GAIN_W  = 16;
    localparam int FRAC_W  = 8;
    localparam int E_W     = SPEED_WIDTH + 1;
    localparam int D1_W    = E_W + 1;
    localparam int D2_W    = E_W + 2;
    localparam int DUTY_W  = 24;
    localparam int STEP_W  = 24;
    localparam int MA_W    = GAIN_W + 1;
    localparam int MB_W    = (D2_W > DUTY_W + 1) ? D2_W : DUTY_W + 1;
    localparam int LO_W    = MB_W - 1;
    localparam int S_W     = D2_W + GAIN_W + 2;
    localparam int HI_W    = S_W - LO_W;
    localparam int ACC_W   = S_W + GAIN_W + 2;
    localparam int CMP_W   = 16;
    localparam int CFG_IDX_W = 3;

    // decay factor 243/256 and drop-out floor of 50 duty units
    localparam logic [7:0]        DECAY_MUL   = 8'd243;
    localparam logic [DUTY_W-1:0] DECAY_FLOOR = DUTY_W'(50 * 256);

    // direction pin patterns (bit 0 forward, bit 1 reverse)
    localparam logic [1:0] PINS_FWD = 2'b01;
    localparam logic [1:0] PINS_REV = 2'b10;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP        = 3'd0,
        CFG_KI_DT     = 3'd1,
        CFG_KD_DT     = 3'd2,
        CFG_MAX_STEP  = 3'd3,
        CFG_MIN_STEP  = 3'd4,
        CFG_MAX_DUTY  = 3'd5,
        CFG_DEAD_BAND = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic        [15:0] kp;
        logic        [15:0] ki_dt;
        logic        [15:0] kd_dt;
        logic signed [15:0] max_step;
        logic signed [15:0] min_step;
        logic        [15:0] max_duty;
        logic        [15:0] dead_band;
    } t_cfg;

    // request payloads
    typedef struct packed {
        logic               motor;
        logic signed [15:0] target_speed;
        logic signed [15:0] measured_speed;
        logic               signal_lost;
    } t_in_item;

    typedef struct packed {
        logic        motor_out;
        logic [15:0] compare;
        logic        drive_a;
        logic        drive_b;
    } t_out_item;

    // last driven direction
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } t_dir;

    // multiply-accumulate commands
    typedef enum logic [2:0] {
        MAC_HOLD,
        MAC_LOAD,
        MAC_MULADD,
        MAC_MUL,
        MAC_MUL_HI
    } t_mac_cmd;

    typedef struct packed {
        t_mac_cmd                 cmd;
        logic signed [MA_W-1:0]   a;
        logic signed [MB_W-1:0]   b;
        logic signed [ACC_W-1:0]  load;
    } t_mac_req;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_KI,
        ST_KD,
        ST_KP_HI,
        ST_KP_LO,
        ST_CLAMP,
        ST_DUTY,
        ST_DECAY,
        ST_DECAY_FIN,
        ST_EMIT
    } t_state;

endpackage

>>> hw/rtl/bmip_mac.sv
`timescale 1ns / 1ps
// ============================================================================
// bmip_mac
// Shared signed multiply-accumulate unit, one product per cycle, driven by
// the controller sequencer.
// ============================================================================
module bmip_mac import bmip_pkg::*; (
    input  logic                    i_clk,
    input  t_mac_req                i_req,
    output logic signed [ACC_W-1:0] o_acc
);

    logic signed [ACC_W-1:0]       r_acc;
    logic signed [ACC_W-1:0]       n_acc;
    logic signed [MA_W+MB_W-1:0]   w_prod;

    // single shared multiplier
    assign w_prod = $signed(i_req.a) * $signed(i_req.b);

    // accumulator update
    always_comb begin
        case (i_req.cmd)
            MAC_HOLD:   n_acc = r_acc;
            MAC_LOAD:   n_acc = i_req.load;
            MAC_MULADD: n_acc = r_acc + ACC_W'(w_prod);
            MAC_MUL:    n_acc = ACC_W'(w_prod);
            MAC_MUL_HI: n_acc = ACC_W'(w_prod) <<< LO_W;
            default:    n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

>>> hw/rtl/bmip_regs.sv
`timescale 1ns / 1ps
// ============================================================================
// bmip_regs
// Configuration register file: gains, step clamps, duty limit and dead band.
// ============================================================================
module bmip_regs import bmip_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // writes are always taken
    assign o_cfg_ready = 1'b1;

    // register write decode, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp        <= 16'd1024;
            r_cfg.ki_dt     <= 16'd1024;
            r_cfg.kd_dt     <= 16'd0;
            r_cfg.max_step  <= 16'sd200;
            r_cfg.min_step  <= -16'sd200;
            r_cfg.max_duty  <= 16'd1000;
            r_cfg.dead_band <= 16'd0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_KP:        r_cfg.kp        <= i_cfg_data;
                CFG_KI_DT:     r_cfg.ki_dt     <= i_cfg_data;
                CFG_KD_DT:     r_cfg.kd_dt     <= i_cfg_data;
                CFG_MAX_STEP:  r_cfg.max_step  <= $signed(i_cfg_data);
                CFG_MIN_STEP:  r_cfg.min_step  <= $signed(i_cfg_data);
                CFG_MAX_DUTY:  r_cfg.max_duty  <= i_cfg_data;
                CFG_DEAD_BAND: r_cfg.dead_band <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/bidirectional_motor_inc_pid.sv
`timescale 1ns / 1ps
// ============================================================================
// bidirectional_motor_inc_pid
// Incremental PID speed controller for up to two bidirectional motors, with
// per-direction duty accumulators, step clamping and idle decay.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) takes one control
//   tick: motor, signed target and measured speed, signal-lost flag.
//   Output channel (o_out_valid / i_out_ready / o_out_item) returns the PWM
//   compare value and direction pins for that motor, at most one per tick.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data)
//   writes the gains and limits; write only while no tick is in flight.
// Sequencing:
//   One tick at a time. A driving tick uses the single shared
//   multiply-accumulate unit, which runs the integral, derivative and two
//   proportional partial products in turn, followed by a clamp step and a
//   duty update step; a decaying tick runs a decay multiply and a duty
//   update, a signal-lost tick goes straight to the result, and a tick
//   with no result returns to idle.
// Reset and stall:
//   Synchronous active-low reset clears all per-motor state and loads the
//   default register values. A stalled receiver holds the result register;
//   a new tick is still accepted and waits in its final cycle until the
//   held result has been taken.
// ============================================================================
module bidirectional_motor_inc_pid import bmip_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    // configuration
    t_cfg w_cfg;

    bmip_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // shared arithmetic unit
    t_mac_req                w_mac_req;
    logic signed [ACC_W-1:0] w_acc;

    bmip_mac u_mac (
        .i_clk (i_clk),
        .i_req (w_mac_req),
        .o_acc (w_acc)
    );

    // control and per-motor state
    t_state                   r_state, n_state;
    logic                     r_out_valid, n_out_valid;
    logic signed [SPEED_WIDTH-1:0] r_prev_target [MOTORS];
    logic signed [SPEED_WIDTH-1:0] n_prev_target [MOTORS];
    logic signed [E_W-1:0]    r_err1 [MOTORS];
    logic signed [E_W-1:0]    n_err1 [MOTORS];
    logic signed [E_W-1:0]    r_err2 [MOTORS];
    logic signed [E_W-1:0]    n_err2 [MOTORS];
    logic [DUTY_W-1:0]        r_fwd_duty [MOTORS];
    logic [DUTY_W-1:0]        n_fwd_duty [MOTORS];
    logic [DUTY_W-1:0]        r_rev_duty [MOTORS];
    logic [DUTY_W-1:0]        n_rev_duty [MOTORS];
    t_dir                     r_last_dir [MOTORS];
    t_dir                     n_last_dir [MOTORS];
    logic [1:0]               r_pins [MOTORS];
    logic [1:0]               n_pins [MOTORS];

    // working payload registers
    t_in_item                 r_item, n_item;
    t_out_item                r_out_item, n_out_item;
    t_dir                     r_dir, n_dir;
    logic signed [E_W-1:0]    r_e, n_e;
    logic signed [D2_W-1:0]   r_d2, n_d2;
    logic [LO_W-1:0]          r_s_lo, n_s_lo;
    logic signed [STEP_W-1:0] r_step, n_step;
    logic [CMP_W-1:0]         r_cmp, n_cmp;
    logic [1:0]               r_out_pins, n_out_pins;

    // error terms of the current tick
    logic                          w_in_range;
    logic signed [SPEED_WIDTH-1:0] w_tgt, w_meas, w_prev;
    logic                          w_block;
    logic signed [E_W-1:0]         w_abs_tgt, w_abs_meas, w_e;
    logic signed [D1_W-1:0]        w_d1;
    logic signed [D2_W-1:0]        w_d2;

    assign w_in_range = (32'(r_item.motor) < MOTORS);
    assign w_tgt      = r_item.target_speed[SPEED_WIDTH-1:0];
    assign w_meas     = r_item.measured_speed[SPEED_WIDTH-1:0];
    assign w_prev     = r_prev_target[r_item.motor];
    assign w_block    = ((w_prev > 0) && (w_tgt < 0)) || ((w_prev < 0) && (w_tgt > 0));
    assign w_abs_tgt  = (w_tgt < 0) ? -E_W'(w_tgt) : E_W'(w_tgt);
    assign w_abs_meas = (w_meas < 0) ? -E_W'(w_meas) : E_W'(w_meas);
    assign w_e        = w_abs_tgt - w_abs_meas;
    assign w_d1       = D1_W'(w_e) - D1_W'(r_err1[r_item.motor]);
    assign w_d2       = D2_W'(w_e) - (D2_W'(r_err1[r_item.motor]) <<< 1)
                      + D2_W'(r_err2[r_item.motor]);

    // step clamp, max first then min
    logic signed [ACC_W-1:0] w_st, w_hi_lim, w_lo_lim, w_st_c1, w_st_c2;

    assign w_st     = w_acc >>> FRAC_W;
    assign w_hi_lim = ACC_W'($signed({w_cfg.max_step, 8'h00}));
    assign w_lo_lim = ACC_W'($signed({w_cfg.min_step, 8'h00}));
    assign w_st_c1  = (w_st > w_hi_lim) ? w_hi_lim : w_st;
    assign w_st_c2  = (w_st_c1 < w_lo_lim) ? w_lo_lim : w_st_c1;

    // duty update and limit
    logic [DUTY_W-1:0]        w_duty_cur;
    logic signed [DUTY_W+1:0] w_sum, w_top, w_lim1, w_lim2;
    logic [DUTY_W-1:0]        w_duty_new;
    logic [CMP_W:0]           w_cmp_sum;

    assign w_duty_cur = (r_dir == DIR_FWD) ? r_fwd_duty[r_item.motor]
                                           : r_rev_duty[r_item.motor];
    assign w_sum      = $signed({2'b00, w_duty_cur}) + (DUTY_W+2)'(r_step);
    assign w_top      = $signed({2'b00, w_cfg.max_duty, 8'h00});
    assign w_lim1     = (w_sum >= w_top) ? w_top : w_sum;
    assign w_lim2     = (w_lim1 <= 0) ? '0 : w_lim1;
    assign w_duty_new = w_lim2[DUTY_W-1:0];
    assign w_cmp_sum  = {1'b0, w_duty_new[DUTY_W-1:FRAC_W]} + {1'b0, w_cfg.dead_band};

    // idle decay result
    logic signed [ACC_W-1:0] w_dec;
    logic [DUTY_W-1:0]       w_dec_duty;

    assign w_dec      = w_acc >>> FRAC_W;
    assign w_dec_duty = (w_dec[DUTY_W-1:0] < DECAY_FLOOR) ? '0 : w_dec[DUTY_W-1:0];

    // sequencer next state and datapath control
    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_prev_target = r_prev_target;
        n_err1        = r_err1;
        n_err2        = r_err2;
        n_fwd_duty    = r_fwd_duty;
        n_rev_duty    = r_rev_duty;
        n_last_dir    = r_last_dir;
        n_pins        = r_pins;
        n_item        = r_item;
        n_out_item    = r_out_item;
        n_dir         = r_dir;
        n_e           = r_e;
        n_d2          = r_d2;
        n_s_lo        = r_s_lo;
        n_step        = r_step;
        n_cmp         = r_cmp;
        n_out_pins    = r_out_pins;
        w_mac_req.cmd  = MAC_HOLD;
        w_mac_req.a    = $signed({1'b0, w_cfg.kp});
        w_mac_req.b    = '0;
        w_mac_req.load = ACC_W'(w_d1) <<< FRAC_W;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_item;
                    n_state = ST_PREP;
                end
            end

            // setpoint selection and error history
            ST_PREP: begin
                if (!w_in_range) begin
                    n_state = ST_IDLE;
                end else if (r_item.signal_lost) begin
                    n_cmp      = '0;
                    n_out_pins = r_pins[r_item.motor];
                    n_state    = ST_EMIT;
                end else if (!w_block && (w_tgt != 0)) begin
                    n_prev_target[r_item.motor] = w_tgt;
                    n_err2[r_item.motor] = r_err1[r_item.motor];
                    n_err1[r_item.motor] = w_e;
                    n_e            = w_e;
                    n_d2           = w_d2;
                    w_mac_req.cmd  = MAC_LOAD;
                    if (w_tgt > 0) begin
                        n_dir = DIR_FWD;
                        n_last_dir[r_item.motor] = DIR_FWD;
                        n_rev_duty[r_item.motor] = '0;
                        n_pins[r_item.motor]     = PINS_FWD;
                        n_out_pins               = PINS_FWD;
                    end else begin
                        n_dir = DIR_REV;
                        n_last_dir[r_item.motor] = DIR_REV;
                        n_fwd_duty[r_item.motor] = '0;
                        n_pins[r_item.motor]     = PINS_REV;
                        n_out_pins               = PINS_REV;
                    end
                    n_state = ST_KI;
                end else begin
                    if (!w_block) begin
                        n_prev_target[r_item.motor] = w_tgt;
                    end
                    case (r_last_dir[r_item.motor])
                        DIR_FWD: begin
                            n_dir = DIR_FWD;
                            n_rev_duty[r_item.motor] = '0;
                            n_pins[r_item.motor]     = PINS_FWD;
                            n_out_pins               = PINS_FWD;
                            n_state                  = ST_DECAY;
                        end
                        DIR_REV: begin
                            n_dir = DIR_REV;
                            n_fwd_duty[r_item.motor] = '0;
                            n_pins[r_item.motor]     = PINS_REV;
                            n_out_pins               = PINS_REV;
                            n_state                  = ST_DECAY;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end

            // integral term
            ST_KI: begin
                w_mac_req.cmd = MAC_MULADD;
                w_mac_req.a   = $signed({1'b0, w_cfg.ki_dt});
                w_mac_req.b   = MB_W'(r_e);
                n_state       = ST_KD;
            end

            // derivative term
            ST_KD: begin
                w_mac_req.cmd = MAC_MULADD;
                w_mac_req.a   = $signed({1'b0, w_cfg.kd_dt});
                w_mac_req.b   = MB_W'(r_d2);
                n_state       = ST_KP_HI;
            end

            // proportional gain, upper part of the sum
            ST_KP_HI: begin
                w_mac_req.cmd = MAC_MUL_HI;
                w_mac_req.b   = MB_W'($signed(w_acc[S_W-1:LO_W]));
                n_s_lo        = w_acc[LO_W-1:0];
                n_state       = ST_KP_LO;
            end

            // proportional gain, lower part of the sum
            ST_KP_LO: begin
                w_mac_req.cmd = MAC_MULADD;
                w_mac_req.b   = $signed({1'b0, r_s_lo});
                n_state       = ST_CLAMP;
            end

            ST_CLAMP: begin
                n_step  = w_st_c2[STEP_W-1:0];
                n_state = ST_DUTY;
            end

            ST_DUTY: begin
                if (r_dir == DIR_FWD) begin
                    n_fwd_duty[r_item.motor] = w_duty_new;
                end else begin
                    n_rev_duty[r_item.motor] = w_duty_new;
                end
                n_cmp   = w_cmp_sum[CMP_W] ? '1 : w_cmp_sum[CMP_W-1:0];
                n_state = ST_EMIT;
            end

            // duty times 243
            ST_DECAY: begin
                w_mac_req.cmd = MAC_MUL;
                w_mac_req.a   = $signed({{(MA_W-8){1'b0}}, DECAY_MUL});
                w_mac_req.b   = MB_W'({1'b0, w_duty_cur});
                n_state       = ST_DECAY_FIN;
            end

            ST_DECAY_FIN: begin
                if (r_dir == DIR_FWD) begin
                    n_fwd_duty[r_item.motor] = w_dec_duty;
                end else begin
                    n_rev_duty[r_item.motor] = w_dec_duty;
                end
                n_cmp   = w_dec_duty[DUTY_W-1:FRAC_W];
                n_state = ST_EMIT;
            end

            // hand the result to the output register once it is free
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_item.motor_out = r_item.motor;
                    n_out_item.compare   = r_cmp;
                    n_out_item.drive_a   = r_out_pins[0];
                    n_out_item.drive_b   = r_out_pins[1];
                    n_out_valid          = 1'b1;
                    n_state              = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control and per-motor state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MOTORS; i++) begin
                r_prev_target[i] <= '0;
                r_err1[i]        <= '0;
                r_err2[i]        <= '0;
                r_fwd_duty[i]    <= '0;
                r_rev_duty[i]    <= '0;
                r_last_dir[i]    <= DIR_NONE;
                r_pins[i]        <= '0;
            end
        end else begin
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
            r_prev_target <= n_prev_target;
            r_err1        <= n_err1;
            r_err2        <= n_err2;
            r_fwd_duty    <= n_fwd_duty;
            r_rev_duty    <= n_rev_duty;
            r_last_dir    <= n_last_dir;
            r_pins        <= n_pins;
        end
    end

    // working payload registers
    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_out_item <= n_out_item;
        r_dir      <= n_dir;
        r_e        <= n_e;
        r_d2       <= n_d2;
        r_s_lo     <= n_s_lo;
        r_step     <= n_step;
        r_cmp      <= n_cmp;
        r_out_pins <= n_out_pins;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> hw/rtl/bmip_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// bmip_checker
// Port-level checks of the speed controller, bound to the top level.
// ============================================================================
module bmip_checker import bmip_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result changed while stalled");

    // one tick at a time: busy right after a request is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while busy");

    // both direction pins never driven together
    a_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.drive_a && o_out_item.drive_b))
        else $error("both direction pins high");

    // reset leaves the block idle with no result
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("not idle after reset");

    // a signal-lost tick still leaves the block busy right after its request
    a_lost_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_item.signal_lost) |=> !o_in_ready)
        else $error("signal-lost request not processed");

endmodule

bind bidirectional_motor_inc_pid bmip_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

>>> tb/sv/tb_bidirectional_motor_inc_pid.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_bidirectional_motor_inc_pid
// Self-checking bench for the two-channel incremental PID speed controller.
// Control ticks go in over a valid/ready request channel. A cycle-free
// predictor keeps its own per-motor duty, error history and pin state and
// works out the compare value and direction pins for each accepted tick.
// Results are matched in order, field by field. A directed part covers
// start-up, direction reversal, signal loss, decay drop-out, saturation and
// negative steps. Random phases then run under a spread of gain and limit
// settings, crossed step clamps and all-zero and all-one registers among them.
// ============================================================================
module tb_bidirectional_motor_inc_pid;
    import bmip_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_TICKS   = 180;

    localparam t_cfg RESET_GAINS = '{kp: 16'd1024, ki_dt: 16'd1024, kd_dt: 16'd0,
                                     max_step: 16'sd200, min_step: -16'sd200,
                                     max_duty: 16'd1000, dead_band: 16'd0};

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #10 clk = ~clk;

    // block ports, all inputs known from time zero
    logic                 in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in_item             in_item   = '0;
    logic                 o_out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            o_out_item;
    logic                 cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data  = '0;

    bidirectional_motor_inc_pid i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // bookkeeping
    t_out_item   expected_q[$];
    t_out_item   want;
    int          failures        = 0;
    int          ticks_sent      = 0;
    int          results_seen    = 0;
    int          settings_loaded = 0;
    int unsigned cycles          = 0;
    bit          idle_on         = 1'b1;
    int          stall_left      = 0;

    // predictor copy of the controller state
    t_cfg       gains = RESET_GAINS;
    longint     prev_target [MOTORS] = '{default: 0};
    longint     err_last    [MOTORS] = '{default: 0};
    longint     err_older   [MOTORS] = '{default: 0};
    longint     fwd_duty    [MOTORS] = '{default: 0};
    longint     rev_duty    [MOTORS] = '{default: 0};
    t_dir       drive_dir   [MOTORS] = '{default: DIR_NONE};
    logic [1:0] pins        [MOTORS] = '{default: 2'b00};

    // random sequence state per motor
    int run_left [MOTORS] = '{default: 0};
    int run_sign [MOTORS] = '{default: 0};

    // clamped incremental PID step in Q.8, updates the error history
    function automatic longint pid_increment(int m, longint setpoint, longint speed);
        longint err, sum, incr, hi, lo;
        err = (setpoint < 0 ? -setpoint : setpoint) - (speed < 0 ? -speed : speed);
        sum = (err - err_last[m]) * 256
            + longint'(gains.ki_dt) * err
            + longint'(gains.kd_dt) * (err - 2 * err_last[m] + err_older[m]);
        incr = (longint'(gains.kp) * sum) >>> 8;
        err_older[m] = err_last[m];
        err_last[m]  = err;
        hi = longint'(gains.max_step) * 256;
        lo = longint'(gains.min_step) * 256;
        // upper clamp first, so the lower one wins when they cross
        if (incr > hi) incr = hi;
        if (incr < lo) incr = lo;
        return incr;
    endfunction

    // duty accumulator limited to 0..max_duty
    function automatic longint limit_duty(longint duty);
        longint top;
        top = longint'(gains.max_duty) * 256;
        if (duty >= top) duty = top;
        if (duty <= 0) duty = 0;
        return duty;
    endfunction

    // idle decay with drop-out below the floor
    function automatic longint decay_duty(longint duty);
        duty = (duty * longint'(DECAY_MUL)) >>> 8;
        if (duty < longint'(DECAY_FLOOR)) duty = 0;
        return duty;
    endfunction

    // expected compare and pins for one accepted tick
    function automatic void predict_tick(t_in_item tick);
        int        m;
        longint    target, setpoint, level;
        t_out_item res;
        m = tick.motor;
        res.motor_out = tick.motor;
        // signal loss: compare zero, held pins, no state change
        if (tick.signal_lost) begin
            res.compare = '0;
            res.drive_a = pins[m][0];
            res.drive_b = pins[m][1];
            expected_q.push_back(res);
            return;
        end
        // a reversal without passing through zero counts as a zero setpoint
        target = tick.target_speed;
        if ((prev_target[m] > 0 && target < 0) || (prev_target[m] < 0 && target > 0)) begin
            setpoint = 0;
        end else begin
            prev_target[m] = target;
            setpoint = target;
        end
        if (setpoint > 0) begin
            drive_dir[m] = DIR_FWD;
            rev_duty[m]  = 0;
            fwd_duty[m]  = limit_duty(fwd_duty[m]
                           + pid_increment(m, setpoint, tick.measured_speed));
            pins[m]      = PINS_FWD;
            level        = (fwd_duty[m] >>> 8) + longint'(gains.dead_band);
        end else if (setpoint < 0) begin
            drive_dir[m] = DIR_REV;
            fwd_duty[m]  = 0;
            rev_duty[m]  = limit_duty(rev_duty[m]
                           + pid_increment(m, setpoint, tick.measured_speed));
            pins[m]      = PINS_REV;
            level        = (rev_duty[m] >>> 8) + longint'(gains.dead_band);
        end else if (drive_dir[m] == DIR_FWD) begin
            rev_duty[m] = 0;
            fwd_duty[m] = decay_duty(fwd_duty[m]);
            pins[m]     = PINS_FWD;
            level       = fwd_duty[m] >>> 8;
        end else if (drive_dir[m] == DIR_REV) begin
            fwd_duty[m] = 0;
            rev_duty[m] = decay_duty(rev_duty[m]);
            pins[m]     = PINS_REV;
            level       = rev_duty[m] >>> 8;
        end else begin
            // never driven and no setpoint: nothing comes out
            return;
        end
        res.compare = (level > 65535) ? 16'hFFFF : 16'(level);
        res.drive_a = pins[m][0];
        res.drive_b = pins[m][1];
        expected_q.push_back(res);
    endfunction

    // directed tick builder
    function automatic t_in_item control_tick(bit motor, int target, int speed, bit lost);
        t_in_item tick;
        tick.motor          = motor;
        tick.target_speed   = 16'(target);
        tick.measured_speed = 16'(speed);
        tick.signal_lost    = lost;
        return tick;
    endfunction

    // random tick: mostly same-sign runs, zero runs among them, plus noise
    function automatic t_in_item make_tick();
        t_in_item tick;
        int       m, mag, meas;
        m = $urandom_range(0, MOTORS - 1);
        if (run_left[m] == 0) begin
            run_left[m] = $urandom_range(1, 12);
            run_sign[m] = int'($urandom_range(0, 2)) - 1;
        end
        run_left[m]--;
        case ($urandom_range(0, 7))
            0: mag = 32767;
            1, 2: mag = $urandom_range(0, 32767);
            default: mag = $urandom_range(0, 2000);
        endcase
        tick.motor       = m[0];
        tick.signal_lost = ($urandom_range(0, 19) == 0);
        if ($urandom_range(0, 15) == 0) begin
            tick.target_speed = 16'($urandom);
        end else begin
            tick.target_speed = 16'(run_sign[m] * mag);
        end
        if ($urandom_range(0, 3) == 0) begin
            tick.measured_speed = 16'($urandom);
        end else begin
            meas = mag + int'($urandom_range(0, 400)) - 200;
            if (meas > 32767) meas = 32767;
            if (meas < 0) meas = 0;
            tick.measured_speed = 16'($urandom_range(0, 1) ? -meas : meas);
        end
        return tick;
    endfunction

    // one tick request; valid stays up into the next tick when there is no gap
    task automatic send_tick(input t_in_item tick);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= tick;
        do @(posedge clk); while (o_in_ready !== 1'b1);
        predict_tick(tick);
        ticks_sent++;
    endtask

    // one register write, valid left to the caller
    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_KP:        gains.kp        = data;
            CFG_KI_DT:     gains.ki_dt     = data;
            CFG_KD_DT:     gains.kd_dt     = data;
            CFG_MAX_STEP:  gains.max_step  = data;
            CFG_MIN_STEP:  gains.min_step  = data;
            CFG_MAX_DUTY:  gains.max_duty  = data;
            CFG_DEAD_BAND: gains.dead_band = data;
            default: ;
        endcase
    endtask

    // full register set, only called while idle
    task automatic load_gains(input t_cfg setting);
        write_reg(CFG_KP, setting.kp);
        write_reg(CFG_KI_DT, setting.ki_dt);
        write_reg(CFG_KD_DT, setting.kd_dt);
        write_reg(CFG_MAX_STEP, setting.max_step);
        write_reg(CFG_MIN_STEP, setting.min_step);
        write_reg(CFG_MAX_DUTY, setting.max_duty);
        write_reg(CFG_DEAD_BAND, setting.dead_band);
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    // drain pending results, then let a silent tick finish
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // reset defaults: start-up, reversal, signal loss on both motors
    task automatic test_direction_and_loss();
        send_tick(control_tick(0, 0, 0, 0));
        send_tick(control_tick(1, 0, 123, 0));
        send_tick(control_tick(0, 0, 0, 1));
        send_tick(control_tick(0, 32767, 0, 0));
        send_tick(control_tick(0, 32767, -32768, 0));
        send_tick(control_tick(0, -5, 0, 0));
        send_tick(control_tick(0, 0, 0, 1));
        send_tick(control_tick(0, 0, 7, 0));
        send_tick(control_tick(0, -32768, 32767, 0));
        send_tick(control_tick(0, -32768, 0, 0));
        send_tick(control_tick(0, 1, 0, 0));
        send_tick(control_tick(1, 500, 400, 0));
        send_tick(control_tick(1, -500, 0, 1));
    endtask

    // compare saturation, negative step to zero duty, decay drop-out
    task automatic test_decay_and_saturation();
        wait_idle();
        load_gains('{kp: 16'd256, ki_dt: 16'd256, kd_dt: 16'd65535,
                     max_step: 16'sd60, min_step: 16'sh8000,
                     max_duty: 16'd55, dead_band: 16'd65535});
        send_tick(control_tick(1, 2000, 100, 0));
        send_tick(control_tick(1, 2000, 2100, 0));
        send_tick(control_tick(1, 2000, 100, 0));
        repeat (4) send_tick(control_tick(1, 0, 0, 0));
        send_tick(control_tick(0, 0, 0, 0));
        send_tick(control_tick(0, -300, -200, 0));
        send_tick(control_tick(0, -300, 32767, 0));
    endtask

    // random ticks under a series of settings, no idling in the last one
    task automatic test_random_settings();
        t_cfg setting;
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: setting = RESET_GAINS;
                1: setting = '{kp: 16'hFFFF, ki_dt: 16'hFFFF, kd_dt: 16'hFFFF,
                               max_step: 16'sh7FFF, min_step: 16'sh8000,
                               max_duty: 16'hFFFF, dead_band: 16'hFFFF};
                2: setting = '{default: '0};
                3: setting = '{kp: 16'($urandom_range(0, 2048)),
                               ki_dt: 16'($urandom_range(0, 2048)),
                               kd_dt: 16'($urandom_range(0, 4096)),
                               max_step: -16'sd50, min_step: 16'sd100,
                               max_duty: 16'($urandom_range(100, 5000)),
                               dead_band: 16'($urandom_range(0, 1000))};
                4: setting = '{kp: 16'($urandom), ki_dt: 16'($urandom),
                               kd_dt: 16'($urandom), max_step: 16'($urandom),
                               min_step: 16'($urandom), max_duty: 16'($urandom),
                               dead_band: 16'($urandom)};
                default: setting = '{kp: 16'($urandom_range(64, 1024)),
                                     ki_dt: 16'($urandom_range(0, 512)),
                                     kd_dt: 16'($urandom_range(0, 256)),
                                     max_step: 16'sd60, min_step: -16'sd60,
                                     max_duty: 16'($urandom_range(55, 400)),
                                     dead_band: 16'($urandom_range(0, 300))};
            endcase
            wait_idle();
            load_gains(setting);
            idle_on = (p < 5);
            repeat (PHASE_TICKS) send_tick(make_tick());
        end
    endtask

    // receiver stalls in bursts, only while idling is on
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 17);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    function automatic void check_field(string name, logic [15:0] exp_val,
                                        logic [15:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            failures++;
        end
    endfunction

    // result request checker, in order against the oldest expectation
    always @(posedge clk) begin
        if (rst_n && o_out_valid === 1'b1 && out_ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                $error("result with nothing pending: motor_out %0d, compare %0d",
                       o_out_item.motor_out, o_out_item.compare);
                failures++;
            end else begin
                want = expected_q.pop_front();
                check_field("motor_out", want.motor_out, o_out_item.motor_out);
                check_field("compare", want.compare, o_out_item.compare);
                check_field("drive_a", want.drive_a, o_out_item.drive_a);
                check_field("drive_b", want.drive_b, o_out_item.drive_b);
            end
        end
    end

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // test sequence
    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_direction_and_loss();
        test_decay_and_saturation();
        test_random_settings();
        wait_idle();
        $display("covered %0d control ticks, %0d results checked, %0d register settings",
                 ticks_sent, results_seen, settings_loaded);
        if (failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
